>>> sv/cirs_pkg.sv
// Shared types and constants for the 2D collision impulse resolver.
package cirs_pkg;

  localparam int JW     = 37;  // impulse magnitude width, sized for the widest component
  localparam int QW     = 17;  // Q0.16 mass fraction, one extra bit holds 1.0
  localparam int SW     = 33;  // inverse-mass sum
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [15:0] GAIN_RST = 16'd13107;
  localparam logic [0:0]  REG_GAIN = 1'b0;

  typedef struct packed {
    logic [63:0]    vel_a;
    logic [63:0]    vel_b;
    logic [63:0]    pos_a;
    logic [63:0]    pos_b;
    logic           has_a;
    logic           has_b;
    logic [31:0]    nrm;
    logic [JW-1:0]  j;
    logic [30:0]    c;
    logic           stat;
    logic [SW-1:0]  sum;
    logic [31:0]    ima;
    logic [31:0]    imb;
  } cirs_fitem_t;

  typedef struct packed {
    logic [63:0]    vel_a;
    logic [63:0]    vel_b;
    logic [63:0]    pos_a;
    logic [63:0]    pos_b;
    logic           has_a;
    logic           has_b;
    logic [31:0]    nrm;
    logic [JW-1:0]  j;
    logic [30:0]    c;
    logic           stat;
    logic [QW-1:0]  fa;
    logic [QW-1:0]  fb;
  } cirs_qitem_t;

endpackage

>>> sv/cirs_front.sv
// Front end: word capture, relative normal speed, impulse magnitude and correction depth.
module cirs_front #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          vel_a,
  input  logic [63:0]          vel_b,
  input  logic [63:0]          pos_a,
  input  logic [63:0]          pos_b,
  input  logic                 has_vel_a,
  input  logic                 has_vel_b,
  input  logic [31:0]          inv_mass_a,
  input  logic [31:0]          inv_mass_b,
  input  logic [15:0]          restitution_a,
  input  logic [15:0]          restitution_b,
  input  logic [31:0]          contact_normal,
  input  logic [30:0]          penetration_depth,
  input  logic [15:0]          gain,
  output logic                 out_valid,
  output cirs_pkg::cirs_fitem_t out_item
);
  import cirs_pkg::*;

  logic        f1_v_r, f2_v_r, f3_v_r, f4_v_r;
  cirs_fitem_t f1_r, f2_r, f3_r, f4_r, f1_nxt, f2_nxt, f4_nxt;
  logic [15:0] f1_ra_r, f1_rb_r;
  logic [30:0] f1_pen_r;

  logic signed [CW+16:0] f2_px_r, f2_py_r;
  logic [15:0]           f2_e_r, f3_e_r;
  logic [CW+3:0]         f3_s_r;

  // stage 1 operands
  logic signed [CW-1:0]  vax, vay, vbx, vby;
  logic signed [CW:0]    dx, dy;
  logic signed [15:0]    nx, ny;
  logic signed [CW+16:0] px, py;
  logic [46:0]           cp;
  logic signed [CW+17:0] rdot;
  logic [CW+17:0]        rmag;
  logic [CW+19:0]        es;

  always_comb begin
    f1_nxt       = '0;
    f1_nxt.vel_a = vel_a;
    f1_nxt.vel_b = vel_b;
    f1_nxt.pos_a = pos_a;
    f1_nxt.pos_b = pos_b;
    f1_nxt.has_a = has_vel_a;
    f1_nxt.has_b = has_vel_b;
    f1_nxt.nrm   = contact_normal;
    f1_nxt.ima   = inv_mass_a;
    f1_nxt.imb   = inv_mass_b;
  end

  assign vax = f1_r.has_a ? $signed(f1_r.vel_a[32 +: CW]) : '0;
  assign vay = f1_r.has_a ? $signed(f1_r.vel_a[0 +: CW])  : '0;
  assign vbx = f1_r.has_b ? $signed(f1_r.vel_b[32 +: CW]) : '0;
  assign vby = f1_r.has_b ? $signed(f1_r.vel_b[0 +: CW])  : '0;
  assign dx  = (CW+1)'(vbx) - (CW+1)'(vax);
  assign dy  = (CW+1)'(vby) - (CW+1)'(vay);
  assign nx  = $signed(f1_r.nrm[31:16]);
  assign ny  = $signed(f1_r.nrm[15:0]);
  assign px  = dx * nx;
  assign py  = dy * ny;
  assign cp  = f1_pen_r * gain;

  always_comb begin
    f2_nxt      = f1_r;
    f2_nxt.sum  = {1'b0, f1_r.ima} + {1'b0, f1_r.imb};
    f2_nxt.stat = (f2_nxt.sum == '0);
    f2_nxt.c    = cp[46:16];
  end

  assign rdot = (CW+18)'(f2_px_r) + (CW+18)'(f2_py_r);
  assign rmag = rdot[CW+17] ? $unsigned(-rdot) : $unsigned(rdot);
  assign es   = f3_e_r * f3_s_r;

  always_comb begin
    f4_nxt   = f3_r;
    f4_nxt.j = JW'(es[CW+19:15]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r     <= f1_nxt;
      f1_ra_r  <= restitution_a;
      f1_rb_r  <= restitution_b;
      f1_pen_r <= penetration_depth;
      f2_r     <= f2_nxt;
      f2_px_r  <= px;
      f2_py_r  <= py;
      f2_e_r   <= (f1_ra_r > f1_rb_r) ? f1_ra_r : f1_rb_r;
      f3_r     <= f2_r;
      f3_e_r   <= f2_e_r;
      f3_s_r   <= rmag[CW+17:14];
      f4_r     <= f4_nxt;
    end
  end

  assign out_valid = f4_v_r;
  assign out_item  = f4_r;

endmodule

>>> sv/cirs_div.sv
// Pipelined restoring dividers for both inverse-mass fractions, one quotient bit per stage.
module cirs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  cirs_pkg::cirs_fitem_t in_item,
  output logic                  out_valid,
  output cirs_pkg::cirs_qitem_t out_item
);
  import cirs_pkg::*;

  localparam int NST = QW;

  logic          st_v_r  [NST];
  cirs_fitem_t   st_it_r [NST];
  logic [SW:0]   rema_r  [NST];
  logic [SW:0]   remb_r  [NST];
  logic [QW-1:0] qa_r    [NST];
  logic [QW-1:0] qb_r    [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic          v_in;
    cirs_fitem_t   it_in;
    logic [SW:0]   ra_in, rb_in, da, db, ra_sel, rb_sel;
    logic [QW-1:0] qa_in, qb_in;
    logic          ge_a, ge_b;

    if (k == 0) begin : g_first
      // quotient < 2^17, so the partial dividend starts as the inverse mass itself
      assign v_in  = in_valid;
      assign it_in = in_item;
      assign ra_in = {2'b00, in_item.ima};
      assign rb_in = {2'b00, in_item.imb};
      assign qa_in = '0;
      assign qb_in = '0;
    end else begin : g_next
      assign v_in  = st_v_r[k-1];
      assign it_in = st_it_r[k-1];
      assign ra_in = rema_r[k-1];
      assign rb_in = remb_r[k-1];
      assign qa_in = qa_r[k-1];
      assign qb_in = qb_r[k-1];
    end

    assign ge_a   = ra_in >= {1'b0, it_in.sum};
    assign ge_b   = rb_in >= {1'b0, it_in.sum};
    assign da     = ra_in - {1'b0, it_in.sum};
    assign db     = rb_in - {1'b0, it_in.sum};
    assign ra_sel = ge_a ? da : ra_in;
    assign rb_sel = ge_b ? db : rb_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[k] <= 1'b0;
      end else if (en) begin
        st_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_it_r[k] <= it_in;
        rema_r[k]  <= {ra_sel[SW-1:0], 1'b0};
        remb_r[k]  <= {rb_sel[SW-1:0], 1'b0};
        qa_r[k]    <= {qa_in[QW-2:0], ge_a};
        qb_r[k]    <= {qb_in[QW-2:0], ge_b};
      end
    end
  end

  always_comb begin
    out_item.vel_a = st_it_r[NST-1].vel_a;
    out_item.vel_b = st_it_r[NST-1].vel_b;
    out_item.pos_a = st_it_r[NST-1].pos_a;
    out_item.pos_b = st_it_r[NST-1].pos_b;
    out_item.has_a = st_it_r[NST-1].has_a;
    out_item.has_b = st_it_r[NST-1].has_b;
    out_item.nrm   = st_it_r[NST-1].nrm;
    out_item.j     = st_it_r[NST-1].j;
    out_item.c     = st_it_r[NST-1].c;
    out_item.stat  = st_it_r[NST-1].stat;
    out_item.fa    = qa_r[NST-1];
    out_item.fb    = qb_r[NST-1];
  end

  assign out_valid = st_v_r[NST-1];

endmodule

>>> sv/cirs_queue.sv
// Short FIFO between the dividers and the update pipeline.
module cirs_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cirs_pkg::cirs_qitem_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output cirs_pkg::cirs_qitem_t head_item
);
  import cirs_pkg::*;

  cirs_qitem_t    mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH)) else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |-> !push) else $error("word pushed into full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1)) else $error("pop miscounted");

endmodule

>>> sv/cirs_back.sv
// Update pipeline: impulse and correction shares, component updates, saturation, output register.
module cirs_back #(
  parameter int CW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cirs_pkg::cirs_qitem_t q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           new_vel_a,
  output logic [63:0]           new_vel_b,
  output logic [63:0]           new_pos_a,
  output logic [63:0]           new_pos_b,
  output logic                  both_static
);
  import cirs_pkg::*;

  localparam int DW = JW + 6;
  localparam logic signed [DW-1:0] SAT_HI = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

  logic        en;
  logic        b1_v_r, b2_v_r, b3_v_r, o_v_r;
  cirs_qitem_t b1_r, b2_r, b3_r;

  logic signed [JW+16:0] jx, jy, b2_jx_r, b2_jy_r;
  logic [47:0]           cap, cbp, b2_cap_r, b2_cbp_r;
  logic signed [15:0]    nx1, ny1, nx2, ny2;

  logic signed [JW+2:0]  ix, iy;
  logic [31:0]           ca, cb;
  logic signed [JW+20:0] vxa, vya, vxb, vyb;
  logic signed [JW+20:0] b3_vxa_r, b3_vya_r, b3_vxb_r, b3_vyb_r;
  logic signed [48:0]    pxa, pya, pxb, pyb;
  logic signed [48:0]    b3_pxa_r, b3_pya_r, b3_pxb_r, b3_pyb_r;

  logic signed [DW-1:0]  vax, vay, vbx, vby, pax, pay, pbx, pby;
  logic signed [DW-1:0]  nvax, nvay, nvbx, nvby, npax, npay, npbx, npby;

  logic [63:0] nva_r, nvb_r, npa_r, npb_r;
  logic        stat_r;

  function automatic logic [31:0] sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return t[31:0];
  endfunction

  assign en    = !o_v_r || out_ready;
  assign q_pop = en && !q_empty;

  // impulse components and correction shares
  assign nx1 = $signed(b1_r.nrm[31:16]);
  assign ny1 = $signed(b1_r.nrm[15:0]);
  assign jx  = $signed({1'b0, b1_r.j}) * nx1;
  assign jy  = $signed({1'b0, b1_r.j}) * ny1;
  assign cap = b1_r.c * b1_r.fa;
  assign cbp = b1_r.c * b1_r.fb;

  assign nx2 = $signed(b2_r.nrm[31:16]);
  assign ny2 = $signed(b2_r.nrm[15:0]);
  assign ix  = b2_jx_r[JW+16:14];
  assign iy  = b2_jy_r[JW+16:14];
  assign ca  = b2_cap_r[47:16];
  assign cb  = b2_cbp_r[47:16];
  assign vxa = ix * $signed({1'b0, b2_r.fa});
  assign vya = iy * $signed({1'b0, b2_r.fa});
  assign vxb = ix * $signed({1'b0, b2_r.fb});
  assign vyb = iy * $signed({1'b0, b2_r.fb});
  assign pxa = $signed({1'b0, ca}) * nx2;
  assign pya = $signed({1'b0, ca}) * ny2;
  assign pxb = $signed({1'b0, cb}) * nx2;
  assign pyb = $signed({1'b0, cb}) * ny2;

  // final sums in a width that cannot wrap
  assign vax = b3_r.has_a ? DW'($signed(b3_r.vel_a[32 +: CW])) : '0;
  assign vay = b3_r.has_a ? DW'($signed(b3_r.vel_a[0 +: CW]))  : '0;
  assign vbx = b3_r.has_b ? DW'($signed(b3_r.vel_b[32 +: CW])) : '0;
  assign vby = b3_r.has_b ? DW'($signed(b3_r.vel_b[0 +: CW]))  : '0;
  assign pax = DW'($signed(b3_r.pos_a[32 +: CW]));
  assign pay = DW'($signed(b3_r.pos_a[0 +: CW]));
  assign pbx = DW'($signed(b3_r.pos_b[32 +: CW]));
  assign pby = DW'($signed(b3_r.pos_b[0 +: CW]));

  assign nvax = vax - DW'($signed(b3_vxa_r[JW+20:16]));
  assign nvay = vay - DW'($signed(b3_vya_r[JW+20:16]));
  assign nvbx = vbx + DW'($signed(b3_vxb_r[JW+20:16]));
  assign nvby = vby + DW'($signed(b3_vyb_r[JW+20:16]));
  assign npax = pax - DW'($signed(b3_pxa_r[48:14]));
  assign npay = pay - DW'($signed(b3_pya_r[48:14]));
  assign npbx = pbx + DW'($signed(b3_pxb_r[48:14]));
  assign npby = pby + DW'($signed(b3_pyb_r[48:14]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      b1_v_r <= q_pop;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      o_v_r  <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r     <= q_item;
      b2_r     <= b1_r;
      b2_jx_r  <= jx;
      b2_jy_r  <= jy;
      b2_cap_r <= cap;
      b2_cbp_r <= cbp;
      b3_r     <= b2_r;
      b3_vxa_r <= vxa;
      b3_vya_r <= vya;
      b3_vxb_r <= vxb;
      b3_vyb_r <= vyb;
      b3_pxa_r <= pxa;
      b3_pya_r <= pya;
      b3_pxb_r <= pxb;
      b3_pyb_r <= pyb;
      stat_r   <= b3_r.stat;
      if (b3_r.stat) begin
        nva_r <= b3_r.vel_a;
        nvb_r <= b3_r.vel_b;
        npa_r <= b3_r.pos_a;
        npb_r <= b3_r.pos_b;
      end else begin
        nva_r <= {sat(nvax), sat(nvay)};
        nvb_r <= {sat(nvbx), sat(nvby)};
        npa_r <= {sat(npax), sat(npay)};
        npb_r <= {sat(npbx), sat(npby)};
      end
    end
  end

  assign out_valid   = o_v_r;
  assign new_vel_a   = nva_r;
  assign new_vel_b   = nvb_r;
  assign new_pos_a   = npa_r;
  assign new_pos_b   = npb_r;
  assign both_static = stat_r;

endmodule

>>> sv/collision_impulse_resolver_2d_core.sv
// Top level of the 2D collision impulse resolver.
//
//  port group | dir | contents
//  in_*       | in  | one contact word per handshake
//  out_*      | out | updated velocities and positions, one word per contact
//  cfg_*      | in  | register access, correction_gain at byte address 0
//
// One contact accepted per cycle while the queue has room; a word comes through
// 4 front stages, 17 stages of the fraction dividers (one quotient bit each),
// the queue and 4 update stages. The dividers set the latency.
// Reset is synchronous; correction_gain returns to 0.2.
// A stalled output backs up the update pipeline; the front keeps running until the
// 4-entry queue is full and a divider word waits, then in_tready drops.
module collision_impulse_resolver_2d_core #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_a[63:0] vel_b[127:64] pos_a[191:128] pos_b[255:192] inv_mass_a[287:256]
  // inv_mass_b[319:288] restitution_a[335:320] restitution_b[351:336]
  // contact_normal[383:352] penetration_depth[414:384], zero pad[415]
  input  logic [415:0] in_tdata,
  // has_vel_a[0] has_vel_b[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_vel_a[63:0] new_vel_b[127:64] new_pos_a[191:128] new_pos_b[255:192]
  output logic [255:0] out_tdata,
  // both_static[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import cirs_pkg::*;

  logic [15:0] gain_r;
  logic        fe_en, fe_v, dv_v, q_full, q_empty, q_pop, q_push;
  cirs_fitem_t fe_item;
  cirs_qitem_t dv_item, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GAIN) ? {16'h0, gain_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_GAIN)) begin
      gain_r <= cfg_pwdata[15:0];
    end
  end

  // front end and dividers move together; they only hold when the queue cannot take a word
  assign fe_en     = !dv_v || !q_full;
  assign q_push    = dv_v && !q_full;
  assign in_tready = fe_en;

  cirs_front #(.CW(COMPONENT_WIDTH)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (fe_en),
    .in_valid          (in_tvalid),
    .vel_a             (in_tdata[63:0]),
    .vel_b             (in_tdata[127:64]),
    .pos_a             (in_tdata[191:128]),
    .pos_b             (in_tdata[255:192]),
    .has_vel_a         (in_tuser[0]),
    .has_vel_b         (in_tuser[1]),
    .inv_mass_a        (in_tdata[287:256]),
    .inv_mass_b        (in_tdata[319:288]),
    .restitution_a     (in_tdata[335:320]),
    .restitution_b     (in_tdata[351:336]),
    .contact_normal    (in_tdata[383:352]),
    .penetration_depth (in_tdata[414:384]),
    .gain              (gain_r),
    .out_valid         (fe_v),
    .out_item          (fe_item)
  );

  cirs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (fe_en),
    .in_valid  (fe_v),
    .in_item   (fe_item),
    .out_valid (dv_v),
    .out_item  (dv_item)
  );

  cirs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (dv_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  cirs_back #(.CW(COMPONENT_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_item      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .new_vel_a   (out_tdata[63:0]),
    .new_vel_b   (out_tdata[127:64]),
    .new_pos_a   (out_tdata[191:128]),
    .new_pos_b   (out_tdata[255:192]),
    .both_static (out_tuser[0])
  );

endmodule

>>> tb/collision_impulse_resolver_2d_core_test.sv
// Self-checking testbench for the 2D collision impulse resolver core.
`timescale 1ns / 100ps

module collision_impulse_resolver_2d_core_test;
  import cirs_pkg::*;

  localparam int CW = 32;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [63:0] vel_a, vel_b, pos_a, pos_b;
    logic        has_a, has_b;
    logic [31:0] ima, imb;
    logic [15:0] rest_a, rest_b;
    logic [31:0] nrm;
    logic [30:0] pen;
  } contact_t;

  typedef struct {
    logic [255:0] data;
    logic         stat;
  } resolved_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [415:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [255:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  resolved_t    resolved_q[$];
  logic [15:0]  gain;
  int           errors = 0;
  int           burst_left = 0;
  int           stall_mode = 0;

  collision_impulse_resolver_2d_core #(.COMPONENT_WIDTH(CW)) dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #20ms;
    $display("collision_impulse_resolver_2d_core_test: done, errors");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint comp_of(logic [31:0] h);
    return longint'($signed(h[CW-1:0]));
  endfunction

  function automatic logic [31:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return 32'(v);
  endfunction

  function automatic resolved_t resolve_contact(contact_t k);
    resolved_t   o;
    longint      nx, ny, vax, vay, vbx, vby, r, j, ix, iy, c, ca, cb, fa, fb;
    logic [63:0] s, e, sum;
    sum = 64'(k.ima) + 64'(k.imb);
    if (sum == 0) begin
      o.data = {k.pos_b, k.pos_a, k.vel_b, k.vel_a};
      o.stat = 1;
      return o;
    end
    nx  = longint'($signed(k.nrm[31:16]));
    ny  = longint'($signed(k.nrm[15:0]));
    vax = k.has_a ? comp_of(k.vel_a[63:32]) : 0;
    vay = k.has_a ? comp_of(k.vel_a[31:0]) : 0;
    vbx = k.has_b ? comp_of(k.vel_b[63:32]) : 0;
    vby = k.has_b ? comp_of(k.vel_b[31:0]) : 0;
    r = (vbx - vax) * nx + (vby - vay) * ny;
    s = (r < 0) ? 64'(-r) : 64'(r);
    s = s >> 14;
    e = (k.rest_a > k.rest_b) ? 64'(k.rest_a) : 64'(k.rest_b);
    j = longint'((e * s) >> 15);
    ix = floor_shr(j * nx, 14);
    iy = floor_shr(j * ny, 14);
    fa = longint'((64'(k.ima) << 16) / sum);
    fb = longint'((64'(k.imb) << 16) / sum);
    o.data[63:0]    = {clamp(vax - floor_shr(ix * fa, 16)), clamp(vay - floor_shr(iy * fa, 16))};
    o.data[127:64]  = {clamp(vbx + floor_shr(ix * fb, 16)), clamp(vby + floor_shr(iy * fb, 16))};
    c  = longint'((64'(k.pen) * 64'(gain)) >> 16);
    ca = floor_shr(c * fa, 16);
    cb = floor_shr(c * fb, 16);
    o.data[191:128] = {clamp(comp_of(k.pos_a[63:32]) - floor_shr(ca * nx, 14)),
                       clamp(comp_of(k.pos_a[31:0]) - floor_shr(ca * ny, 14))};
    o.data[255:192] = {clamp(comp_of(k.pos_b[63:32]) + floor_shr(cb * nx, 14)),
                       clamp(comp_of(k.pos_b[31:0]) + floor_shr(cb * ny, 14))};
    o.stat = 0;
    return o;
  endfunction

  // receiver stall pattern: mode 0 never stalls, 1 stalls often, 2 on a slow beat
  int beat = 0;
  always @(posedge clk) begin
    beat <= beat + 1;
    case (stall_mode)
      0: out_tready <= 1;
      1: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (beat % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    resolved_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (resolved_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        x = resolved_q.pop_front();
        if (out_tdata[63:0] !== x.data[63:0]) begin
          $error("new_vel_a exp %h got %h", x.data[63:0], out_tdata[63:0]); errors++;
        end
        if (out_tdata[127:64] !== x.data[127:64]) begin
          $error("new_vel_b exp %h got %h", x.data[127:64], out_tdata[127:64]); errors++;
        end
        if (out_tdata[191:128] !== x.data[191:128]) begin
          $error("new_pos_a exp %h got %h", x.data[191:128], out_tdata[191:128]); errors++;
        end
        if (out_tdata[255:192] !== x.data[255:192]) begin
          $error("new_pos_b exp %h got %h", x.data[255:192], out_tdata[255:192]); errors++;
        end
        if (out_tuser[0] !== x.stat) begin
          $error("both_static exp %b got %b", x.stat, out_tuser[0]); errors++;
        end
      end
    end
  end

  task automatic send_contact(contact_t k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1;
    in_tdata  <= {1'b0, k.pen, k.nrm, k.rest_b, k.rest_a, k.imb, k.ima,
                  k.pos_b, k.pos_a, k.vel_b, k.vel_a};
    in_tuser  <= {k.has_b, k.has_a};
    resolved_q.push_back(resolve_contact(k));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_sending;
    in_tvalid <= 0;
    burst_left = 0;
  endtask

  task automatic wait_idle;
    int n;
    stop_sending();
    n = 0;
    while (resolved_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 3'(REG_GAIN) << 2; cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    gain = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic contact_t rnd_contact();
    contact_t k;
    int       ang;
    k.vel_a = {rnd_comp(), rnd_comp()};
    k.vel_b = {rnd_comp(), rnd_comp()};
    k.pos_a = {rnd_comp(), rnd_comp()};
    k.pos_b = {rnd_comp(), rnd_comp()};
    k.has_a = $urandom_range(0, 3) != 0;
    k.has_b = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 7))
      0: begin k.ima = 0; k.imb = 0; end
      1: begin k.ima = 0; k.imb = $urandom; end
      2: begin k.ima = $urandom; k.imb = 0; end
      3: begin k.ima = 32'hFFFF_FFFF; k.imb = 32'hFFFF_FFFF; end
      default: begin k.ima = $urandom_range(1, 1 << 20); k.imb = $urandom_range(1, 1 << 20); end
    endcase
    k.rest_a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    k.rest_b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    ang = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) k.nrm = $urandom;
    else case (ang)
      0: k.nrm = {16'h4000, 16'h0000};
      1: k.nrm = {16'h0000, 16'hC000};
      2: k.nrm = {16'h2D41, 16'hD2BF};
      default: k.nrm = {16'hC000, 16'h0000};
    endcase
    k.pen = ($urandom_range(0, 7) == 0) ? 31'h7FFF_FFFF : 31'($urandom);
    return k;
  endfunction

  task automatic test_directed;
    contact_t k;
    for (int i = 0; i < 24; i++) begin
      k = rnd_contact();
      case (i % 8)
        0: begin k.ima = 0; k.imb = 0; end                       // both immovable
        1: begin k.has_a = 0; k.has_b = 0; end
        2: begin k.rest_a = 16'hFFFF; k.rest_b = 16'h0000; end  // restitution above one
        3: begin k.nrm = 32'h7FFF_8000; end                     // non-unit normal
        4: begin k.vel_a = {2{32'h8000_0000}}; k.vel_b = {2{32'h7FFF_FFFF}};
                 k.ima = 32'hFFFF_FFFF; k.imb = 32'hFFFF_FFFF; k.has_a = 1; k.has_b = 1; end
        5: begin k.pen = 31'h7FFF_FFFF; k.pos_a = {2{32'h7FFF_FFFF}};
                 k.pos_b = {2{32'h8000_0000}}; end
        6: begin k.vel_a = '0; k.vel_b = '0; k.pos_a = '1; k.pos_b = '1; k.pen = 0; end
        default: begin k.rest_a = 16'd32768; k.rest_b = 16'd32768; end
      endcase
      send_contact(k);
    end
    wait_idle();
  endtask

  task automatic test_random(int count, int mode);
    stall_mode = mode;
    for (int i = 0; i < count; i++) send_contact(rnd_contact());
    wait_idle();
  endtask

  task automatic test_gain_sweep;
    logic [15:0] g[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd13107};
    foreach (g[i]) begin
      write_gain(g[i]);
      test_random(60, i % 3);
    end
  endtask

  initial begin
    gain = GAIN_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(300, 0);
    test_random(300, 1);
    test_random(300, 2);
    test_gain_sweep();
    if (errors == 0)
      $display("collision_impulse_resolver_2d_core_test: done, clean");
    else
      $display("collision_impulse_resolver_2d_core_test: done, errors");
    $finish;
  end

endmodule

>>> collision_impulse_resolver_2d_core.f
sv/cirs_pkg.sv
sv/cirs_front.sv
sv/cirs_div.sv
sv/cirs_queue.sv
sv/cirs_back.sv
sv/collision_impulse_resolver_2d_core.sv
tb/collision_impulse_resolver_2d_core_test.sv
